@@ hdl/ptb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants of the page table builder: operation and
// status codes, entry bit masks and page sizes.
// ----------------------------------------------------------------------------
package ptb_pkg;

  typedef logic [1:0] status_t;
  typedef logic [1:0] op_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_INVALID = 2'd1;
  localparam status_t STATUS_NO_RES  = 2'd2;

  localparam op_t OP_MAP_PAGE   = 2'd0;
  localparam op_t OP_MAP_REGION = 2'd1;
  localparam op_t OP_READ       = 2'd2;
  localparam op_t OP_NONE       = 2'd3;

  localparam logic [1:0] SIZE_4K  = 2'd0;
  localparam logic [1:0] SIZE_2M  = 2'd1;
  localparam logic [1:0] SIZE_1G  = 2'd2;
  localparam logic [1:0] SIZE_BAD = 2'd3;

  // Entry bits.
  localparam logic [63:0] BIT_P  = 64'h1;
  localparam logic [63:0] BIT_W  = 64'h2;
  localparam logic [63:0] BIT_PS = 64'h80;

  localparam logic [40:0] STEP_4K = 41'h1000;
  localparam logic [40:0] STEP_2M = 41'h200000;

endpackage

@@ hdl/ptb_table_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_table_mem
// Table entry store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ptb_table_mem #(
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [2**AW];

  // Read before write on a shared address; read data lands in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/page_table_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_builder
// Builds four-level x86-64 page tables in a pool of table pages.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table store to zero, one entry a cycle,
// and takes no word until the sweep ends; configuration writes are taken at
// all times. All table state lives in one memory with one read and one write
// port, and each table level is walked in ST_WALK, which reads the entry, and
// then ST_EVAL, which checks it and writes it back. A read word presents its
// index on acceptance and takes the entry in ST_RDWAIT; a single-page map
// walks from the top level down to its leaf, and a region map does so once
// for each page. One word is worked on at a time; a finished result waits in
// the output register while the next word is accepted.
module page_table_builder #(
  parameter int POOL_PAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [51:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [51:0] in_phys_addr,
  input  logic [47:0] in_virt_addr,
  input  logic [40:0] in_region_size,
  input  logic [1:0]  in_page_size,
  input  logic        in_not_present,
  input  logic [63:0] in_leaf_flags,
  input  logic [12:0] in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_entry,
  output logic [4:0]  out_pages_used,
  output logic        out_pool_exhausted
);

  localparam int ENTRIES = POOL_PAGES * 512;
  localparam int AW      = $clog2(ENTRIES);
  localparam int PW      = AW - 9;
  localparam int NW      = $clog2(POOL_PAGES + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PAGE, ST_WALK, ST_EVAL, ST_RDWAIT, ST_FINISH
  } state_t;

  state_t             state_r;
  logic [AW-1:0]      clr_r;
  logic [51:0]        pool_base_r;
  logic [NW-1:0]      nfp_r;
  logic               exh_r;
  logic               region_r;
  logic [51:0]        cp_r;
  logic [47:0]        cv_r;
  logic [40:0]        rem_r;
  logic [63:0]        flags_r;
  logic [63:0]        leaf_r;
  logic [1:0]         lvl_r;
  logic [1:0]         leaf_lvl_r;
  logic               big_r;
  logic [PW-1:0]      tbl_r;
  logic [AW-1:0]      slot_r;
  logic               rd_oob_r;
  ptb_pkg::status_t   res_status_r;
  logic [63:0]        res_rd_r;
  logic               out_valid_r;
  ptb_pkg::status_t   out_status_r;
  logic [63:0]        out_rd_r;
  logic [NW-1:0]      out_pages_r;
  logic               out_exh_r;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [63:0]        mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [63:0]        mem_rdata;

  logic               accept;
  logic [31:0]        idx_ext;
  logic [8:0]         walk_idx;
  logic [AW-1:0]      walk_slot;
  logic [39:0]        nfp_ext;
  logic [39:0]        ptr_off;
  logic               foreign;
  logic               pool_empty;
  logic [63:0]        ptr_entry;
  logic [63:0]        page_aphys;
  logic               reg_big;
  logic [40:0]        step;
  logic [40:0]        rem_next;
  logic [31:0]        pages_ext;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign idx_ext    = {19'd0, in_entry_index};
  assign nfp_ext    = {{(40-NW){1'b0}}, nfp_r};
  assign pool_empty = (nfp_r >= NW'(POOL_PAGES));

  // Table index for the level being walked.
  always_comb begin
    case (lvl_r)
      2'd3:    walk_idx = cv_r[47:39];
      2'd2:    walk_idx = cv_r[38:30];
      2'd1:    walk_idx = cv_r[29:21];
      default: walk_idx = cv_r[20:12];
    endcase
  end
  assign walk_slot = {tbl_r, walk_idx};

  // Present pointer check and new pointer value.
  assign ptr_off   = mem_rdata[51:12] - pool_base_r[51:12];
  assign foreign   = (ptr_off == 40'd0) || (ptr_off >= nfp_ext);
  assign ptr_entry = {12'd0, pool_base_r[51:12] + nfp_ext, 12'd0} | ptb_pkg::BIT_P
                     | ptb_pkg::BIT_W;

  // Leaf physical address for a single-page map.
  always_comb begin
    case (in_page_size)
      ptb_pkg::SIZE_2M: page_aphys = {12'd0, in_phys_addr[51:21], 21'd0};
      ptb_pkg::SIZE_1G: page_aphys = {12'd0, in_phys_addr[51:30], 30'd0};
      default:          page_aphys = {12'd0, in_phys_addr[51:12], 12'd0};
    endcase
  end

  // Region page choice and remaining length.
  assign reg_big  = (rem_r >= ptb_pkg::STEP_2M) && (cp_r[20:0] == 21'd0) &&
                    (cv_r[20:0] == 21'd0);
  assign step     = big_r ? ptb_pkg::STEP_2M : ptb_pkg::STEP_4K;
  assign rem_next = (rem_r <= step) ? 41'd0 : rem_r - step;

  // Memory ports.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = leaf_r;
    mem_raddr = walk_slot;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = 64'd0;
    end else if (state_r == ST_IDLE) begin
      mem_raddr = idx_ext[AW-1:0];
    end else if (state_r == ST_EVAL) begin
      if (lvl_r == leaf_lvl_r) begin
        mem_we = !mem_rdata[0];
      end else begin
        mem_we    = !mem_rdata[0] && !pool_empty;
        mem_wdata = ptr_entry;
      end
    end
  end

  ptb_table_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= 52'd0;
    end else if (cfg_we) begin
      pool_base_r <= cfg_wdata;
    end
  end

  // Sequencer: clear sweep, operation decode, table walk and result hand-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      nfp_r       <= NW'(1);
      exh_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one lands now.
      if (out_valid_r && out_ready && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(ENTRIES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_status_r <= ptb_pkg::STATUS_OK;
            res_rd_r     <= 64'd0;
            flags_r      <= in_leaf_flags;
            cp_r         <= in_phys_addr;
            cv_r         <= in_virt_addr;
            rem_r        <= in_region_size;
            lvl_r        <= 2'd3;
            tbl_r        <= '0;
            rd_oob_r     <= (idx_ext >= 32'(ENTRIES));
            case (in_operation)
              ptb_pkg::OP_MAP_PAGE: begin
                region_r   <= 1'b0;
                leaf_lvl_r <= in_page_size;
                leaf_r     <= page_aphys | in_leaf_flags
                              | ((in_page_size != ptb_pkg::SIZE_4K) ? ptb_pkg::BIT_PS : 64'd0)
                              | (in_not_present ? 64'd0 : ptb_pkg::BIT_P);
                if (in_page_size == ptb_pkg::SIZE_BAD) begin
                  res_status_r <= ptb_pkg::STATUS_INVALID;
                  state_r      <= ST_FINISH;
                end else begin
                  state_r <= ST_WALK;
                end
              end
              ptb_pkg::OP_MAP_REGION: begin
                region_r <= 1'b1;
                if (exh_r) begin
                  res_status_r <= ptb_pkg::STATUS_NO_RES;
                  state_r      <= ST_FINISH;
                end else if (in_region_size == 41'd0) begin
                  state_r <= ST_FINISH;
                end else begin
                  state_r <= ST_PAGE;
                end
              end
              ptb_pkg::OP_READ: begin
                state_r <= ST_RDWAIT;
              end
              default: begin
                res_status_r <= ptb_pkg::STATUS_INVALID;
                state_r      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_PAGE: begin
          big_r      <= reg_big;
          leaf_lvl_r <= reg_big ? 2'd1 : 2'd0;
          leaf_r     <= {12'd0, cp_r[51:12], 12'd0} | flags_r | ptb_pkg::BIT_P
                        | (reg_big ? ptb_pkg::BIT_PS : 64'd0);
          lvl_r      <= 2'd3;
          tbl_r      <= '0;
          state_r    <= ST_WALK;
        end
        ST_WALK: begin
          slot_r  <= walk_slot;
          state_r <= ST_EVAL;
        end
        ST_EVAL: begin
          if (lvl_r == leaf_lvl_r) begin
            if (mem_rdata[0]) begin
              res_status_r <= ptb_pkg::STATUS_INVALID;
              state_r      <= ST_FINISH;
            end else if (region_r && rem_next != 41'd0) begin
              cp_r    <= cp_r + {11'd0, step};
              cv_r    <= cv_r + {7'd0, step};
              rem_r   <= rem_next;
              state_r <= ST_PAGE;
            end else begin
              state_r <= ST_FINISH;
            end
          end else if (!mem_rdata[0]) begin
            // Missing table: allocate the next pool page.
            if (pool_empty) begin
              exh_r        <= 1'b1;
              res_status_r <= ptb_pkg::STATUS_NO_RES;
              state_r      <= ST_FINISH;
            end else begin
              tbl_r   <= nfp_r[PW-1:0];
              nfp_r   <= nfp_r + NW'(1);
              lvl_r   <= lvl_r - 2'd1;
              state_r <= ST_WALK;
            end
          end else if (mem_rdata[7] || foreign) begin
            res_status_r <= ptb_pkg::STATUS_INVALID;
            state_r      <= ST_FINISH;
          end else begin
            tbl_r   <= ptr_off[PW-1:0];
            lvl_r   <= lvl_r - 2'd1;
            state_r <= ST_WALK;
          end
        end
        ST_RDWAIT: begin
          res_rd_r <= rd_oob_r ? 64'd0 : mem_rdata;
          state_r  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_rd_r     <= res_rd_r;
            out_pages_r  <= nfp_r;
            out_exh_r    <= exh_r;
            state_r      <= ST_IDLE;
          end else if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign pages_ext          = {{(32-NW){1'b0}}, out_pages_r};
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_entry     = out_rd_r;
  assign out_pages_used     = pages_ext[4:0];
  assign out_pool_exhausted = out_exh_r;

`ifndef NO_ASSERTIONS
  // The allocator never hands out more pages than the pool holds.
  a_nfp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nfp_r <= NW'(POOL_PAGES))
    else $error("allocator ran past the pool");

  // The exhausted flag is sticky.
  a_exh_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    exh_r |=> exh_r)
    else $error("exhausted flag cleared");

  // No table write happens while waiting for a word.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("table write while idle");

  // An allocation always comes with a pointer write.
  a_alloc_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL && lvl_r != leaf_lvl_r && !mem_rdata[0] && !pool_empty)
      |-> mem_we)
    else $error("allocation without pointer write");
`endif

endmodule
